FILE: hdl/bdcd_pkg.sv
// ----------------------------------------------------------------------------
// bdcd_pkg
// Shared types and constants for the button debounce and click detector.
// ----------------------------------------------------------------------------
package bdcd_pkg;

  localparam int unsigned TIMER_BITS_DEF = 16;
  localparam int unsigned CFG_W          = 16;
  localparam int unsigned APB_DATA_W     = 32;
  localparam int unsigned APB_ADDR_W     = 4;
  localparam int unsigned CFG_IDX_W      = 2;

  localparam logic LOW = 1'b0;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd50;
  localparam logic [CFG_W-1:0] LONG_RST     = 16'd1000;
  localparam logic [CFG_W-1:0] DOUBLE_RST   = 16'd400;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE = 2'd0,
    CFG_LONG     = 2'd1,
    CFG_DOUBLE   = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_ticks;
    logic [CFG_W-1:0] long_press_ticks;
    logic [CFG_W-1:0] double_click_ticks;
  } cfg_t;

  typedef struct packed {
    logic pin_level;
    logic clear_press;
    logic clear_long;
    logic clear_double;
  } tick_t;

  typedef struct packed {
    logic held_now;
    logic press_pending;
    logic long_pending;
    logic double_pending;
  } result_t;

endpackage

FILE: hdl/bdcd_if.sv
// ----------------------------------------------------------------------------
// bdcd_tick_if / bdcd_result_if
// Valid/ready channels for tick items and result items.
// ----------------------------------------------------------------------------
interface bdcd_tick_if;
  logic valid;
  logic ready;
  logic pin_level;
  logic clear_press;
  logic clear_long;
  logic clear_double;

  modport source (output valid, pin_level, clear_press, clear_long, clear_double,
                  input ready);
  modport sink (input valid, pin_level, clear_press, clear_long, clear_double,
                output ready);
endinterface

interface bdcd_result_if;
  logic valid;
  logic ready;
  logic held_now;
  logic press_pending;
  logic long_pending;
  logic double_pending;

  modport source (output valid, held_now, press_pending, long_pending, double_pending,
                  input ready);
  modport sink (input valid, held_now, press_pending, long_pending, double_pending,
                output ready);
endinterface

FILE: hdl/bdcd_cfg_regs.sv
// ----------------------------------------------------------------------------
// bdcd_cfg_regs
// APB register file holding the three timing thresholds.
// ----------------------------------------------------------------------------
module bdcd_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bdcd_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [bdcd_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [bdcd_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready,
  output bdcd_pkg::cfg_t                    cfg
);

  bdcd_pkg::cfg_t                      cfg_r;
  logic                                wr_en;
  logic [bdcd_pkg::CFG_IDX_W-1:0]      idx;
  logic [bdcd_pkg::CFG_W-1:0]          wdata;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[bdcd_pkg::APB_ADDR_W-1:2];
  assign wdata  = pwdata[bdcd_pkg::CFG_W-1:0];
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks     <= bdcd_pkg::DEBOUNCE_RST;
      cfg_r.long_press_ticks   <= bdcd_pkg::LONG_RST;
      cfg_r.double_click_ticks <= bdcd_pkg::DOUBLE_RST;
    end else if (wr_en) begin
      unique case (idx)
        bdcd_pkg::CFG_DEBOUNCE: cfg_r.debounce_ticks     <= wdata;
        bdcd_pkg::CFG_LONG:     cfg_r.long_press_ticks   <= wdata;
        bdcd_pkg::CFG_DOUBLE:   cfg_r.double_click_ticks <= wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      bdcd_pkg::CFG_DEBOUNCE: prdata = bdcd_pkg::APB_DATA_W'(cfg_r.debounce_ticks);
      bdcd_pkg::CFG_LONG:     prdata = bdcd_pkg::APB_DATA_W'(cfg_r.long_press_ticks);
      bdcd_pkg::CFG_DOUBLE:   prdata = bdcd_pkg::APB_DATA_W'(cfg_r.double_click_ticks);
      default:                prdata = '0;
    endcase
  end

endmodule

FILE: hdl/bdcd_core.sv
// ----------------------------------------------------------------------------
// bdcd_core
// Debounce state, hold and click timers, and latched event flags.
// ----------------------------------------------------------------------------
module bdcd_core #(
  parameter int unsigned TIMER_BITS = bdcd_pkg::TIMER_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  bdcd_pkg::tick_t   tick,
  input  bdcd_pkg::cfg_t    cfg,
  output bdcd_pkg::result_t result
);

  localparam int unsigned TW = TIMER_BITS;
  localparam int unsigned CW = (TIMER_BITS > bdcd_pkg::CFG_W) ? TIMER_BITS : bdcd_pkg::CFG_W;

  logic          prev_raw_r,  level_r,  fired_r,  win_r,  pf_r,  lf_r,  df_r;
  logic          level_nxt,   fired_nxt, win_nxt, pf_nxt, lf_nxt, df_nxt;
  logic [TW-1:0] steady_r, hold_r, since_r;
  logic [TW-1:0] stable, hold, since;
  logic          accept_chg;

  function automatic logic [TW-1:0] sat_inc(input logic [TW-1:0] v);
    sat_inc = (&v) ? v : v + TW'(1);
  endfunction

  always_comb begin
    pf_nxt    = pf_r && !tick.clear_press;
    lf_nxt    = lf_r && !tick.clear_long;
    df_nxt    = df_r && !tick.clear_double;
    level_nxt = level_r;
    fired_nxt = fired_r;
    win_nxt   = win_r;
    hold      = hold_r;
    since     = since_r;
    stable    = (tick.pin_level != prev_raw_r) ? '0 : steady_r;

    accept_chg = (CW'(stable) > CW'(cfg.debounce_ticks)) && (tick.pin_level != level_r);
    if (accept_chg) begin
      level_nxt = tick.pin_level;
      if (tick.pin_level == bdcd_pkg::LOW) begin
        hold      = '0;
        fired_nxt = 1'b0;
      end else if (!fired_r) begin
        if (win_r && (CW'(since_r) < CW'(cfg.double_click_ticks))) begin
          df_nxt  = 1'b1;
          win_nxt = 1'b0;
        end else begin
          pf_nxt  = 1'b1;
          win_nxt = 1'b1;
          since   = '0;
        end
      end
    end

    if ((level_nxt == bdcd_pkg::LOW) && !fired_nxt &&
        (CW'(hold) >= CW'(cfg.long_press_ticks))) begin
      lf_nxt    = 1'b1;
      fired_nxt = 1'b1;
      win_nxt   = 1'b0;
    end

    result.held_now       = (level_nxt == bdcd_pkg::LOW);
    result.press_pending  = pf_nxt;
    result.long_pending   = lf_nxt;
    result.double_pending = df_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_raw_r <= 1'b1;
      level_r    <= 1'b1;
      steady_r   <= '0;
      hold_r     <= '0;
      since_r    <= '0;
      win_r      <= 1'b0;
      fired_r    <= 1'b0;
      pf_r       <= 1'b0;
      lf_r       <= 1'b0;
      df_r       <= 1'b0;
    end else if (advance) begin
      prev_raw_r <= tick.pin_level;
      level_r    <= level_nxt;
      steady_r   <= sat_inc(stable);
      hold_r     <= sat_inc(hold);
      since_r    <= sat_inc(since);
      win_r      <= win_nxt;
      fired_r    <= fired_nxt;
      pf_r       <= pf_nxt;
      lf_r       <= lf_nxt;
      df_r       <= df_nxt;
    end
  end

  a_window_closed_after_long: assert property (@(posedge clk) disable iff (!rst_n)
    (fired_r && (level_r == bdcd_pkg::LOW)) |-> !win_r)
    else $error("click window open during a fired long hold");

  a_flags_move_on_item: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(pf_r) || $rose(lf_r) || $rose(df_r)) |-> $past(advance))
    else $error("event flag set without an item");

  a_state_holds_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$past(advance) |-> $stable(steady_r) && $stable(level_r))
    else $error("state changed without an item");

endmodule

FILE: hdl/button_debounce_click_detector_unit.sv
// ----------------------------------------------------------------------------
// button_debounce_click_detector_unit
// Debounces a sampled active-low button and reports single press, long
// press and double click as latched flags, one result item per tick item.
//
// in_tick carries one millisecond tick item: raw pin level and three flag
// clears. out_result returns one item per tick: debounced held state and the
// three latched flags as they stand after that tick. Thresholds sit in three
// 16-bit registers on the cfg_ APB port at byte offsets 0, 4 and 8.
// An accepted item sits in the input register until the state update writes
// its result into the result register, from which out_result presents it.
// The block takes one item per cycle while out_result is not stalled; the
// state update is a single pass of compare and increment logic. While
// out_result is stalled the block still takes one more item into its input
// register, then drops in_tick.ready.
// Synchronous reset empties both registers, restores the thresholds to
// 50, 1000 and 400 ticks and returns the button to released with all flags
// and timers cleared.
// ----------------------------------------------------------------------------
module button_debounce_click_detector_unit #(
  parameter int unsigned TIMER_BITS = bdcd_pkg::TIMER_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  bdcd_tick_if.sink                         in_tick,
  bdcd_result_if.source                     out_result,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [bdcd_pkg::APB_ADDR_W-1:0]   cfg_paddr,
  input  logic [bdcd_pkg::APB_DATA_W-1:0]   cfg_pwdata,
  output logic [bdcd_pkg::APB_DATA_W-1:0]   cfg_prdata,
  output logic                              cfg_pready
);

  bdcd_pkg::cfg_t    cfg;
  bdcd_pkg::tick_t   tick_r;
  bdcd_pkg::result_t res, res_r;
  logic              s1_valid_r, out_valid_r;
  logic              advance, in_take;

  assign advance = s1_valid_r && (!out_valid_r || out_result.ready);
  assign in_tick.ready = !s1_valid_r || advance;
  assign in_take = in_tick.valid && in_tick.ready;

  bdcd_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  bdcd_core #(.TIMER_BITS(TIMER_BITS)) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .tick    (tick_r),
    .cfg     (cfg),
    .result  (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_result.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      tick_r.pin_level    <= in_tick.pin_level;
      tick_r.clear_press  <= in_tick.clear_press;
      tick_r.clear_long   <= in_tick.clear_long;
      tick_r.clear_double <= in_tick.clear_double;
    end
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_result.valid          = out_valid_r;
  assign out_result.held_now       = res_r.held_now;
  assign out_result.press_pending  = res_r.press_pending;
  assign out_result.long_pending   = res_r.long_pending;
  assign out_result.double_pending = res_r.double_pending;

  a_empty_after_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid_r && !s1_valid_r)
    else $error("pipeline not empty after reset");

  a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("item lost between stages");

  a_stall_keeps_item: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !advance) |=> s1_valid_r && $stable(tick_r))
    else $error("stalled item dropped or changed");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the button debounce and click detector. A directed
// table walks reset values, threshold extremes, press, release, double click
// and long press, then random press and release episodes with bounce and
// noise run under several threshold settings. Typed rows are checked against
// the row, other items against this bench's cycle-free debounce/click model.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned TIMER_MAX = (1 << bdcd_pkg::TIMER_BITS_DEF) - 1;
  localparam int unsigned PHASES = 12;
  localparam int unsigned PHASE_TICKS = 140;

  typedef enum logic {ROW_TICK, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t                  kind;
    bdcd_pkg::tick_t            stim;
    bit                         typed;
    bdcd_pkg::result_t          want;
    bdcd_pkg::cfg_idx_t         reg_idx;
    logic [bdcd_pkg::CFG_W-1:0] value;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                            cfg_psel;
  logic                            cfg_penable;
  logic                            cfg_pwrite;
  logic [bdcd_pkg::APB_ADDR_W-1:0] cfg_paddr;
  logic [bdcd_pkg::APB_DATA_W-1:0] cfg_pwdata;
  logic [bdcd_pkg::APB_DATA_W-1:0] cfg_prdata;
  logic                            cfg_pready;

  bdcd_tick_if   tick_ch ();
  bdcd_result_if result_ch ();

  button_debounce_click_detector_unit #(
    .TIMER_BITS(bdcd_pkg::TIMER_BITS_DEF)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tick    (tick_ch),
    .out_result (result_ch),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #4 clk = ~clk;

  // button model
  bdcd_pkg::cfg_t thresholds;
  logic           raw_last;
  logic           level_now;
  int unsigned    steady_ticks;
  int unsigned    hold_ticks;
  int unsigned    click_age;
  bit             window_open;
  bit             long_done;
  bit             press_latch;
  bit             long_latch;
  bit             double_latch;

  bdcd_pkg::result_t flag_reports_due[$];
  int unsigned       ticks_sent = 0;
  int unsigned       mismatches = 0;
  bit                quiet = 1'b0;
  bit                hold_off_due = 1'b0;

  function automatic int unsigned sat_next(int unsigned v);
    return (v >= TIMER_MAX) ? TIMER_MAX : v + 1;
  endfunction

  function automatic void reset_button();
    thresholds.debounce_ticks     = bdcd_pkg::DEBOUNCE_RST;
    thresholds.long_press_ticks   = bdcd_pkg::LONG_RST;
    thresholds.double_click_ticks = bdcd_pkg::DOUBLE_RST;
    raw_last     = 1'b1;
    level_now    = 1'b1;
    steady_ticks = 0;
    hold_ticks   = 0;
    click_age    = 0;
    window_open  = 1'b0;
    long_done    = 1'b0;
    press_latch  = 1'b0;
    long_latch   = 1'b0;
    double_latch = 1'b0;
  endfunction

  function automatic bdcd_pkg::result_t advance_button(bdcd_pkg::tick_t t);
    int unsigned       stable;
    int unsigned       hold;
    int unsigned       age;
    bdcd_pkg::result_t r;
    hold = hold_ticks;
    age  = click_age;
    if (t.clear_press) press_latch = 1'b0;
    if (t.clear_long) long_latch = 1'b0;
    if (t.clear_double) double_latch = 1'b0;
    stable = (t.pin_level != raw_last) ? 0 : steady_ticks;
    if (stable > thresholds.debounce_ticks && t.pin_level != level_now) begin
      level_now = t.pin_level;
      if (level_now == bdcd_pkg::LOW) begin
        hold      = 0;
        long_done = 1'b0;
      end else if (!long_done) begin
        if (window_open && age < thresholds.double_click_ticks) begin
          double_latch = 1'b1;
          window_open  = 1'b0;
        end else begin
          press_latch = 1'b1;
          window_open = 1'b1;
          age         = 0;
        end
      end
    end
    if (level_now == bdcd_pkg::LOW && !long_done && hold >= thresholds.long_press_ticks) begin
      long_latch  = 1'b1;
      long_done   = 1'b1;
      window_open = 1'b0;
    end
    raw_last     = t.pin_level;
    steady_ticks = sat_next(stable);
    hold_ticks   = sat_next(hold);
    click_age    = sat_next(age);
    r.held_now       = (level_now == bdcd_pkg::LOW);
    r.press_pending  = press_latch;
    r.long_pending   = long_latch;
    r.double_pending = double_latch;
    return r;
  endfunction

  task automatic send_tick(input bdcd_pkg::tick_t t, input bit typed,
                           input bdcd_pkg::result_t want);
    bdcd_pkg::result_t due;
    while (!quiet && $urandom_range(0, 99) < 24) begin
      tick_ch.valid <= 1'b0;
      @(posedge clk);
    end
    tick_ch.valid        <= 1'b1;
    tick_ch.pin_level    <= t.pin_level;
    tick_ch.clear_press  <= t.clear_press;
    tick_ch.clear_long   <= t.clear_long;
    tick_ch.clear_double <= t.clear_double;
    do @(posedge clk); while (!tick_ch.ready);
    due = advance_button(t);
    flag_reports_due.push_back(typed ? want : due);
    ticks_sent++;
  endtask

  // drop valid and wait until every result item is back
  task automatic settle();
    tick_ch.valid <= 1'b0;
    while (flag_reports_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_access(input bdcd_pkg::cfg_idx_t idx, input bit wr,
                            input logic [bdcd_pkg::CFG_W-1:0] val);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= {{(bdcd_pkg::APB_DATA_W-bdcd_pkg::CFG_W){1'b0}}, val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (!wr && cfg_prdata[bdcd_pkg::CFG_W-1:0] !== val) begin
      mismatches++;
      $display("%0t ns: register %s read expected %0d, got %0d", $time, idx.name(), val,
               cfg_prdata[bdcd_pkg::CFG_W-1:0]);
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  function automatic logic [bdcd_pkg::CFG_W-1:0] threshold_of(bdcd_pkg::cfg_idx_t idx);
    unique case (idx)
      bdcd_pkg::CFG_DEBOUNCE: return thresholds.debounce_ticks;
      bdcd_pkg::CFG_LONG:     return thresholds.long_press_ticks;
      default:                return thresholds.double_click_ticks;
    endcase
  endfunction

  task automatic write_threshold(input bdcd_pkg::cfg_idx_t idx,
                                 input logic [bdcd_pkg::CFG_W-1:0] val);
    apb_access(idx, 1'b1, val);
    unique case (idx)
      bdcd_pkg::CFG_DEBOUNCE: thresholds.debounce_ticks = val;
      bdcd_pkg::CFG_LONG:     thresholds.long_press_ticks = val;
      default:                thresholds.double_click_ticks = val;
    endcase
    apb_access(idx, 1'b0, threshold_of(idx));
  endtask

  task automatic program_thresholds(input logic [bdcd_pkg::CFG_W-1:0] d,
                                    input logic [bdcd_pkg::CFG_W-1:0] l,
                                    input logic [bdcd_pkg::CFG_W-1:0] w);
    settle();
    write_threshold(bdcd_pkg::CFG_DEBOUNCE, d);
    write_threshold(bdcd_pkg::CFG_LONG, l);
    write_threshold(bdcd_pkg::CFG_DOUBLE, w);
  endtask

  function automatic bdcd_pkg::tick_t make_tick(logic lvl);
    bdcd_pkg::tick_t t;
    t.pin_level    = lvl;
    t.clear_press  = ($urandom_range(0, 5) == 0);
    t.clear_long   = ($urandom_range(0, 5) == 0);
    t.clear_double = ($urandom_range(0, 5) == 0);
    return t;
  endfunction

  task automatic emit_level(input logic lvl, input int unsigned n);
    repeat (n) send_tick(make_tick(lvl), 1'b0, '0);
  endtask

  task automatic emit_noise(input int unsigned n);
    repeat (n) send_tick(make_tick(logic'($urandom_range(0, 1))), 1'b0, '0);
  endtask

  // one press and release with bounce, or a burst of noise
  task automatic run_episode();
    int unsigned dcap;
    int unsigned lcap;
    int unsigned wcap;
    dcap = (thresholds.debounce_ticks > 6) ? 6 : thresholds.debounce_ticks;
    lcap = (thresholds.long_press_ticks > 40) ? 40 : thresholds.long_press_ticks;
    wcap = (thresholds.double_click_ticks > 40) ? 40 : thresholds.double_click_ticks;
    if ($urandom_range(0, 99) < 15) begin
      emit_noise($urandom_range(1, 10));
    end else begin
      emit_noise($urandom_range(0, 3));
      emit_level(bdcd_pkg::LOW, dcap + 2 + $urandom_range(0, lcap + 4));
      emit_noise($urandom_range(0, 2));
      emit_level(1'b1, dcap + 2 + $urandom_range(0, wcap + 4));
    end
  endtask

  function automatic logic [bdcd_pkg::CFG_W-1:0] pick_threshold(int unsigned hi);
    return ($urandom_range(0, 9) == 0) ? {bdcd_pkg::CFG_W{1'b1}} :
                                         bdcd_pkg::CFG_W'($urandom_range(0, hi));
  endfunction

  dir_row_t steps[] = '{
    '{ROW_TICK, 4'b1000, 1'b1, 4'b0000, bdcd_pkg::CFG_DEBOUNCE, 16'd0},
    '{ROW_TICK, 4'b0000, 1'b1, 4'b0000, bdcd_pkg::CFG_DEBOUNCE, 16'd0},
    '{ROW_TICK, 4'b1111, 1'b1, 4'b0000, bdcd_pkg::CFG_DEBOUNCE, 16'd0},
    '{ROW_CFG,  4'b0000, 1'b0, 4'b0000, bdcd_pkg::CFG_DEBOUNCE, 16'd0},
    '{ROW_CFG,  4'b0000, 1'b0, 4'b0000, bdcd_pkg::CFG_LONG,     16'd2},
    '{ROW_CFG,  4'b0000, 1'b0, 4'b0000, bdcd_pkg::CFG_DOUBLE,   16'd65535},
    '{ROW_TICK, 4'b0000, 1'b0, 4'b0000, bdcd_pkg::CFG_DEBOUNCE, 16'd0},
    '{ROW_TICK, 4'b0000, 1'b0, 4'b0000, bdcd_pkg::CFG_DEBOUNCE, 16'd0},
    '{ROW_TICK, 4'b1000, 1'b0, 4'b0000, bdcd_pkg::CFG_DEBOUNCE, 16'd0},
    '{ROW_TICK, 4'b1100, 1'b0, 4'b0000, bdcd_pkg::CFG_DEBOUNCE, 16'd0},
    '{ROW_TICK, 4'b0100, 1'b0, 4'b0000, bdcd_pkg::CFG_DEBOUNCE, 16'd0},
    '{ROW_TICK, 4'b0000, 1'b0, 4'b0000, bdcd_pkg::CFG_DEBOUNCE, 16'd0},
    '{ROW_TICK, 4'b1000, 1'b0, 4'b0000, bdcd_pkg::CFG_DEBOUNCE, 16'd0},
    '{ROW_TICK, 4'b1000, 1'b0, 4'b0000, bdcd_pkg::CFG_DEBOUNCE, 16'd0},
    '{ROW_TICK, 4'b0001, 1'b0, 4'b0000, bdcd_pkg::CFG_DEBOUNCE, 16'd0},
    '{ROW_TICK, 4'b0000, 1'b0, 4'b0000, bdcd_pkg::CFG_DEBOUNCE, 16'd0},
    '{ROW_TICK, 4'b0000, 1'b0, 4'b0000, bdcd_pkg::CFG_DEBOUNCE, 16'd0},
    '{ROW_TICK, 4'b0000, 1'b0, 4'b0000, bdcd_pkg::CFG_DEBOUNCE, 16'd0},
    '{ROW_TICK, 4'b1010, 1'b0, 4'b0000, bdcd_pkg::CFG_DEBOUNCE, 16'd0},
    '{ROW_TICK, 4'b1000, 1'b0, 4'b0000, bdcd_pkg::CFG_DEBOUNCE, 16'd0},
    '{ROW_CFG,  4'b0000, 1'b0, 4'b0000, bdcd_pkg::CFG_LONG,     16'd0},
    '{ROW_TICK, 4'b0000, 1'b0, 4'b0000, bdcd_pkg::CFG_DEBOUNCE, 16'd0},
    '{ROW_TICK, 4'b0010, 1'b0, 4'b0000, bdcd_pkg::CFG_DEBOUNCE, 16'd0},
    '{ROW_CFG,  4'b0000, 1'b0, 4'b0000, bdcd_pkg::CFG_DEBOUNCE, 16'd65535},
    '{ROW_TICK, 4'b1000, 1'b0, 4'b0000, bdcd_pkg::CFG_DEBOUNCE, 16'd0},
    '{ROW_TICK, 4'b1000, 1'b0, 4'b0000, bdcd_pkg::CFG_DEBOUNCE, 16'd0},
    '{ROW_TICK, 4'b0111, 1'b0, 4'b0000, bdcd_pkg::CFG_DEBOUNCE, 16'd0},
    '{ROW_TICK, 4'b0000, 1'b0, 4'b0000, bdcd_pkg::CFG_DEBOUNCE, 16'd0}
  };

  initial begin
    int unsigned                phase_start;
    logic [bdcd_pkg::CFG_W-1:0] d;
    logic [bdcd_pkg::CFG_W-1:0] l;
    logic [bdcd_pkg::CFG_W-1:0] w;
    rst_n                <= 1'b0;
    tick_ch.valid        <= 1'b0;
    tick_ch.pin_level    <= 1'b1;
    tick_ch.clear_press  <= 1'b0;
    tick_ch.clear_long   <= 1'b0;
    tick_ch.clear_double <= 1'b0;
    cfg_psel             <= 1'b0;
    cfg_penable          <= 1'b0;
    cfg_pwrite           <= 1'b0;
    cfg_paddr            <= '0;
    cfg_pwdata           <= '0;
    reset_button();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    apb_access(bdcd_pkg::CFG_DEBOUNCE, 1'b0, bdcd_pkg::DEBOUNCE_RST);
    apb_access(bdcd_pkg::CFG_LONG, 1'b0, bdcd_pkg::LONG_RST);
    apb_access(bdcd_pkg::CFG_DOUBLE, 1'b0, bdcd_pkg::DOUBLE_RST);

    foreach (steps[i]) begin
      if (steps[i].kind == ROW_CFG) begin
        settle();
        write_threshold(steps[i].reg_idx, steps[i].value);
      end else begin
        send_tick(steps[i].stim, steps[i].typed, steps[i].want);
      end
    end

    for (int unsigned p = 0; p < PHASES; p++) begin
      unique case (p)
        0:       begin d = 16'd0;     l = 16'd0;     w = 16'd0;     end
        1:       begin d = 16'hFFFF;  l = 16'hFFFF;  w = 16'hFFFF;  end
        2:       begin d = 16'd0;     l = 16'hFFFF;  w = 16'hFFFF;  end
        3:       begin d = 16'd1;     l = 16'd5;     w = 16'd10;    end
        default: begin
          d = pick_threshold(4);
          l = pick_threshold(40);
          w = pick_threshold(40);
        end
      endcase
      program_thresholds(d, l, w);
      quiet = (p == 3);
      if (p == 5) hold_off_due = 1'b1;
      phase_start = ticks_sent;
      while (ticks_sent - phase_start < PHASE_TICKS) run_episode();
    end
    quiet = 1'b0;

    // click twice inside the window
    program_thresholds(16'd0, 16'hFFFF, 16'hFFFF);
    emit_level(bdcd_pkg::LOW, 2);
    emit_level(1'b1, 3);
    emit_level(bdcd_pkg::LOW, 2);
    emit_level(1'b1, 3);

    settle();
    repeat (6) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_due) begin
        hold_off_due = 1'b0;
        result_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
      end
      result_ch.ready <= quiet || ($urandom_range(0, 99) >= 24);
    end
  end

  always @(posedge clk) begin
    logic [3:0] got;
    logic [3:0] want;
    string      field_name [4];
    field_name = '{"double_pending", "long_pending", "press_pending", "held_now"};
    if (rst_n && result_ch.valid && result_ch.ready) begin
      got = {result_ch.held_now, result_ch.press_pending, result_ch.long_pending,
             result_ch.double_pending};
      if (flag_reports_due.size() == 0) begin
        mismatches++;
        $display("%0t ns: result item %b with none expected", $time, got);
      end else begin
        want = flag_reports_due.pop_front();
        for (int i = 0; i < 4; i++) begin
          if (got[i] !== want[i]) begin
            mismatches++;
            $display("%0t ns: %s expected %b, got %b", $time, field_name[i], want[i], got[i]);
          end
        end
      end
    end
  end

  initial begin
    #40_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

FILE: filelist.f
hdl/bdcd_pkg.sv
hdl/bdcd_if.sv
hdl/bdcd_cfg_regs.sv
hdl/bdcd_core.sv
hdl/button_debounce_click_detector_unit.sv
tb/tb_top.sv
